FILE: hdl/utfdec_pkg.sv
// Shared types, constants and helper functions for the escaping code-point decoder.
package utfdec_pkg;

    // Default depth of the token queue between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Most tokens one input unit can raise: three held bytes plus the new unit
    localparam int MAX_TOKENS = 4;

    // Register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // source_encoding codes
    localparam logic ENC_UTF8  = 1'b0;
    localparam logic ENC_UTF16 = 1'b1;

    // Escape characters
    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] CP_LETTER_U    = 21'h000075;

    // UTF-16 surrogate ranges
    localparam logic [15:0] SURR_HI_FIRST = 16'hD800;
    localparam logic [15:0] SURR_HI_LAST  = 16'hDBFF;
    localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
    localparam logic [15:0] SURR_LO_LAST  = 16'hDFFF;
    localparam logic [15:0] SURR_END      = 16'hE000;
    localparam logic [31:0] SURR_OFFSET   = 32'h035FDC00;

    // UTF-8 lead byte classes
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [1:0] CONT_PAT   = 2'b10;

    // What the back end does with one token
    typedef enum logic [1:0] {
        TOK_LIT,
        TOK_ESC8,
        TOK_ESC16
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [20:0] value;
        logic        run_last;
        logic        string_last;
    } token_t;

    // Upper-case hex digit as a code point
    function automatic logic [20:0] hex_digit(input logic [3:0] v);
        logic [7:0] d;
        if (v < 4'd10)
            d = 8'h30 + {4'b0, v};
        else
            d = 8'h37 + {4'b0, v};
        return {13'b0, d};
    endfunction

endpackage

FILE: hdl/utf8_utf16_to_utf32_escaping_decoder.sv
// Top level of the escaping UTF-8 / UTF-16 to code-point decoder.
// Units enter through push/full and code points leave through empty/pop. A unit that
// completes a character, or a single ASCII byte / BMP unit, gives one result; a unit
// that only extends a sequence gives none. The front end takes one unit per cycle while
// each unit raises at most one token and the queue has room; a unit that also escapes
// held units raises up to four tokens, which the front end issues in order, keeping full
// high until the last one goes to the queue. While results are popped, the back end turns each token
// into one result per cycle: a plain character is one result, a UTF-8 escape three,
// a UTF-16 escape six, and while it expands escapes the token queue fills and full
// rises. No clearing pass is needed after reset. Register 0 at byte address 0 holds
// source_encoding (bit 0: 0 = UTF-8, 1 = UTF-16); writing it drops any sequence in
// progress and should only be done with the block idle.
module utf8_utf16_to_utf32_escaping_decoder #(
    parameter int QUEUE_DEPTH = utfdec_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [utfdec_pkg::PADDR_W-1:0]    paddr,
    input  logic [utfdec_pkg::PDATA_W-1:0]    pwdata,
    output logic [utfdec_pkg::PDATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              push,
    output logic                              full,
    input  logic [15:0]                       unit,
    input  logic                              end_of_string,
    output logic                              empty,
    input  logic                              pop,
    output logic [20:0]                       code_point,
    output logic                              run_last,
    output logic                              string_last
);
    import utfdec_pkg::*;

    logic   source_encoding_reg;
    logic   cfg_write;
    logic   q_push, q_full, q_pop, q_empty;
    token_t q_wdata, q_rdata;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {{(PDATA_W-1){1'b0}}, source_encoding_reg}
                                          : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            source_encoding_reg <= ENC_UTF8;
        else if (cfg_write)
            source_encoding_reg <= pwdata[0];
    end

    // Front end
    utfdec_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (source_encoding_reg),
        .clear         (cfg_write),
        .push          (push),
        .full          (full),
        .unit          (unit),
        .end_of_string (end_of_string),
        .q_push        (q_push),
        .q_data        (q_wdata),
        .q_full        (q_full)
    );

    // Token queue
    utfdec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // Back end
    utfdec_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .code_point  (code_point),
        .run_last    (run_last),
        .string_last (string_last)
    );

endmodule

FILE: hdl/utfdec_front.sv
// Front end: accepts code units, tracks the sequence in progress and issues tokens.
module utfdec_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 mode,
    input  logic                 clear,
    input  logic                 push,
    output logic                 full,
    input  logic [15:0]          unit,
    input  logic                 end_of_string,
    output logic                 q_push,
    output utfdec_pkg::token_t   q_data,
    input  logic                 q_full
);
    import utfdec_pkg::*;

    // Sequence state
    logic [15:0] held0_reg;
    logic [7:0]  held1_reg;
    logic [7:0]  held2_reg;
    logic [1:0]  count_reg, count_next;
    logic [2:0]  len_reg, len_next;

    // Token buffer for the item being issued
    token_t      tok_reg [MAX_TOKENS];
    token_t      tok_next [MAX_TOKENS];
    logic [2:0]  rem_reg;
    logic [1:0]  idx_reg;

    logic [7:0]  byte_in;
    logic [15:0] lead_unit;
    logic [2:0]  len8;
    logic        is_surr, is_high, is_low, is_cont;
    logic        lead_hold;
    logic [2:0]  lead_len;
    logic        lead_fin;
    tok_kind_t   lead_kind;
    logic [20:0] lead_value;
    logic [1:0]  esc_n;
    logic        fin_valid;
    tok_kind_t   fin_kind;
    logic [20:0] fin_value;
    logic        wr_lead, wr_append;
    logic [2:0]  n_tok;
    logic [20:0] held_ext [3];
    logic [20:0] assembled;
    logic [31:0] pair_sum;
    logic        in_ready, accept;

    // Handshake with input side and queue
    assign q_data   = tok_reg[idx_reg];
    assign q_push   = (rem_reg != 3'd0) && !q_full;
    assign in_ready = (rem_reg == 3'd0) || (q_push && rem_reg == 3'd1);
    assign full     = !in_ready;
    assign accept   = push && in_ready;

    // Classification of the incoming unit
    always_comb
    begin
        byte_in   = unit[7:0];
        lead_unit = (mode == ENC_UTF16) ? unit : {8'b0, byte_in};
        is_cont   = (byte_in[7:6] == CONT_PAT);
        is_surr   = (unit >= SURR_HI_FIRST) && (unit < SURR_END);
        is_high   = (unit <= SURR_HI_LAST);
        is_low    = (unit >= SURR_LO_FIRST) && (unit <= SURR_LO_LAST);

        if ((byte_in & LEAD2_MASK) == LEAD2_PAT)
            len8 = 3'd2;
        else if ((byte_in & LEAD3_MASK) == LEAD3_PAT)
            len8 = 3'd3;
        else if ((byte_in & LEAD4_MASK) == LEAD4_PAT)
            len8 = 3'd4;
        else
            len8 = 3'd0;

        // Unit taken as a fresh lead
        lead_hold  = 1'b0;
        lead_len   = 3'd0;
        lead_fin   = 1'b1;
        lead_kind  = TOK_LIT;
        lead_value = {5'b0, lead_unit};
        if (mode == ENC_UTF8) begin
            if (byte_in[7]) begin
                if (len8 != 3'd0 && !end_of_string) begin
                    lead_hold = 1'b1;
                    lead_len  = len8;
                    lead_fin  = 1'b0;
                end
                else begin
                    lead_kind = TOK_ESC8;
                end
            end
        end
        else begin
            if (is_surr) begin
                if (is_high && !end_of_string) begin
                    lead_hold = 1'b1;
                    lead_len  = 3'd2;
                    lead_fin  = 1'b0;
                end
                else begin
                    lead_kind = TOK_ESC16;
                end
            end
        end

        // Completed code points
        case (len_reg)
            3'd2:    assembled = {10'b0, held0_reg[4:0], byte_in[5:0]};
            3'd3:    assembled = {5'b0, held0_reg[3:0], held1_reg[5:0], byte_in[5:0]};
            default: assembled = {held0_reg[2:0], held1_reg[5:0], held2_reg[5:0],
                                  byte_in[5:0]};
        endcase
        pair_sum = ({16'b0, held0_reg} << 10) + {16'b0, unit} - SURR_OFFSET;

        // Sequence step
        esc_n      = 2'd0;
        fin_valid  = 1'b0;
        fin_kind   = TOK_LIT;
        fin_value  = lead_value;
        wr_lead    = 1'b0;
        wr_append  = 1'b0;
        count_next = 2'd0;
        len_next   = 3'd0;
        if (count_reg == 2'd0) begin
            fin_valid = lead_fin;
            fin_kind  = lead_kind;
            wr_lead   = lead_hold;
        end
        else if (mode == ENC_UTF8 && is_cont) begin
            if ({1'b0, count_reg} + 3'd1 >= len_reg) begin
                fin_valid = 1'b1;
                fin_value = assembled;
            end
            else if (end_of_string) begin
                esc_n     = count_reg;
                fin_valid = 1'b1;
                fin_kind  = TOK_ESC8;
            end
            else begin
                wr_append  = 1'b1;
                count_next = count_reg + 2'd1;
                len_next   = len_reg;
            end
        end
        else if (mode == ENC_UTF16 && is_low) begin
            fin_valid = 1'b1;
            fin_value = pair_sum[20:0];
        end
        else begin
            // Escape what is held, then restart on this unit
            esc_n     = (mode == ENC_UTF8) ? count_reg : 2'd1;
            fin_valid = lead_fin;
            fin_kind  = lead_kind;
            wr_lead   = lead_hold;
        end
        if (wr_lead) begin
            count_next = 2'd1;
            len_next   = lead_len;
        end
        if (end_of_string) begin
            count_next = 2'd0;
            len_next   = 3'd0;
        end

        // Token list: held escapes first, then the final token
        held_ext[0] = {5'b0, held0_reg};
        held_ext[1] = {13'b0, held1_reg};
        held_ext[2] = {13'b0, held2_reg};
        n_tok = {1'b0, esc_n} + {2'b0, fin_valid};
        for (int k = 0; k < MAX_TOKENS; k++) begin
            if (3'(k) < {1'b0, esc_n}) begin
                tok_next[k].kind  = (mode == ENC_UTF16) ? TOK_ESC16 : TOK_ESC8;
                tok_next[k].value = held_ext[(k < 3) ? k : 0];
            end
            else begin
                tok_next[k].kind  = fin_kind;
                tok_next[k].value = fin_value;
            end
            tok_next[k].run_last    = (3'(k) + 3'd1 == n_tok);
            tok_next[k].string_last = (3'(k) + 3'd1 == n_tok) && end_of_string;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 2'd0;
            len_reg   <= 3'd0;
            rem_reg   <= 3'd0;
            idx_reg   <= 2'd0;
        end
        else begin
            if (clear) begin
                count_reg <= 2'd0;
                len_reg   <= 3'd0;
            end
            else if (accept) begin
                count_reg <= count_next;
                len_reg   <= len_next;
            end
            if (accept) begin
                rem_reg <= n_tok;
                idx_reg <= 2'd0;
            end
            else if (q_push) begin
                rem_reg <= rem_reg - 3'd1;
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // Held units and token buffer
    always_ff @(posedge clk)
    begin
        if (accept) begin
            for (int k = 0; k < MAX_TOKENS; k++)
                tok_reg[k] <= tok_next[k];
            if (wr_lead)
                held0_reg <= lead_unit;
            if (wr_append) begin
                if (count_reg == 2'd1)
                    held1_reg <= byte_in;
                else
                    held2_reg <= byte_in;
            end
        end
    end

endmodule

FILE: hdl/utfdec_queue.sv
// Token queue between front and back end.
module utfdec_queue #(
    parameter int DEPTH = utfdec_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  utfdec_pkg::token_t   wdata,
    output logic                 full,
    input  logic                 pop,
    output utfdec_pkg::token_t   rdata,
    output logic                 empty
);
    import utfdec_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    token_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

FILE: hdl/utfdec_back.sv
// Back end: expands tokens into code points, one result per cycle while results are popped.
module utfdec_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  utfdec_pkg::token_t   q_data,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic [20:0]          code_point,
    output logic                 run_last,
    output logic                 string_last
);
    import utfdec_pkg::*;

    token_t      cur_reg;
    logic        cur_valid_reg;
    logic [2:0]  step_reg;
    logic        out_valid_reg;
    logic [20:0] out_cp_reg;
    logic        out_run_last_reg;
    logic        out_string_last_reg;

    logic [2:0]  last_step;
    logic [20:0] res_cp;
    logic        at_last, load_out, cur_done;

    assign empty       = !out_valid_reg;
    assign code_point  = out_cp_reg;
    assign run_last    = out_run_last_reg;
    assign string_last = out_string_last_reg;

    // Result selection for the current step
    always_comb
    begin
        res_cp    = cur_reg.value;
        last_step = 3'd0;
        case (cur_reg.kind)
            TOK_LIT:
            begin
                res_cp    = cur_reg.value;
                last_step = 3'd0;
            end
            TOK_ESC8:
            begin
                last_step = 3'd2;
                case (step_reg)
                    3'd0:    res_cp = CP_REPLACEMENT;
                    3'd1:    res_cp = hex_digit(cur_reg.value[7:4]);
                    default: res_cp = hex_digit(cur_reg.value[3:0]);
                endcase
            end
            TOK_ESC16:
            begin
                last_step = 3'd5;
                case (step_reg)
                    3'd0:    res_cp = CP_REPLACEMENT;
                    3'd1:    res_cp = CP_LETTER_U;
                    3'd2:    res_cp = hex_digit(cur_reg.value[15:12]);
                    3'd3:    res_cp = hex_digit(cur_reg.value[11:8]);
                    3'd4:    res_cp = hex_digit(cur_reg.value[7:4]);
                    default: res_cp = hex_digit(cur_reg.value[3:0]);
                endcase
            end
            default:
            begin
                res_cp    = cur_reg.value;
                last_step = 3'd0;
            end
        endcase
        at_last  = (step_reg == last_step);
        load_out = cur_valid_reg && (!out_valid_reg || pop);
        cur_done = load_out && at_last;
        q_pop    = !q_empty && (!cur_valid_reg || cur_done);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                step_reg      <= 3'd0;
            end
            else if (cur_done) begin
                cur_valid_reg <= 1'b0;
            end
            else if (load_out) begin
                step_reg <= step_reg + 3'd1;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    // Token and result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_data;
        if (load_out) begin
            out_cp_reg          <= res_cp;
            out_run_last_reg    <= cur_reg.run_last && at_last;
            out_string_last_reg <= cur_reg.string_last && at_last;
        end
    end

endmodule

FILE: hdl/utfdec_checker.sv
// Port-level checks for the decoder, bound to the top level.
module utfdec_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [utfdec_pkg::PADDR_W-1:0]    paddr,
    input logic [utfdec_pkg::PDATA_W-1:0]    pwdata,
    input logic [utfdec_pkg::PDATA_W-1:0]    prdata,
    input logic                              pready,
    input logic                              empty,
    input logic                              pop,
    input logic [20:0]                       code_point,
    input logic                              run_last,
    input logic                              string_last
);

    // A waiting result holds until it is transferred
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(code_point) && $stable(run_last)
                              && $stable(string_last)))
    else $error("waiting result changed before transfer");

    // End of string only ever closes an input's run of results
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && string_last) |-> run_last)
    else $error("string_last without run_last");

    // Only the encoding bit reads back
    assert property (@(posedge clk) disable iff (!rst_n)
        prdata[utfdec_pkg::PDATA_W-1:1] == '0)
    else $error("unused register bits read non-zero");

    // A write to the encoding register reads back next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr == '0)
            |=> (paddr[2] == 1'b1 || prdata[0] == $past(pwdata[0])))
    else $error("encoding register did not take the written value");

endmodule

bind utf8_utf16_to_utf32_escaping_decoder utfdec_checker u_checker (.*);

FILE: tb/sv/tb.sv
// Self-checking testbench for the escaping UTF-8 / UTF-16 to code-point decoder.
`timescale 1ns / 100ps

module tb;
    import utfdec_pkg::*;

    // Register addresses: source_encoding, and one unmapped word that must be ignored
    localparam logic [PADDR_W-1:0] ADDR_SRC_ENC  = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

    localparam int MAX_CPS_PER_UNIT = 12;
    localparam int DRAIN_CYCLES     = 32;
    localparam int WATCHDOG_LIMIT   = 4000;

    typedef struct {
        logic [15:0] u;
        logic        eos;
    } unit_item_t;

    typedef struct {
        logic [20:0] cp;
        logic        rl;
        logic        sl;
    } cp_result_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                push = 1'b0;
    logic                full;
    logic [15:0]         unit = '0;
    logic                end_of_string = 1'b0;
    logic                empty;
    logic                pop = 1'b0;
    logic [20:0]         code_point;
    logic                run_last;
    logic                string_last;

    // Stimulus and expectations
    unit_item_t  unit_fifo[$];
    cp_result_t  pending_cps[$];
    logic [20:0] step_cps[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;
    int idle_run      = 0;
    bit timed_out     = 0;

    // Decoder state as the block should hold it
    logic        src_enc;
    logic [15:0] held[3];
    int unsigned held_n;
    int unsigned seq_len;

    utf8_utf16_to_utf32_escaping_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .unit          (unit),
        .end_of_string (end_of_string),
        .empty         (empty),
        .pop           (pop),
        .code_point    (code_point),
        .run_last      (run_last),
        .string_last   (string_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    function automatic logic [20:0] hex_char(input logic [3:0] v);
        logic [7:0] d;
        if (v < 4'd10)
            d = 8'h30 + {4'b0, v};
        else
            d = 8'h41 + {4'b0, v} - 8'd10;
        return {13'b0, d};
    endfunction

    function automatic void emit(input logic [20:0] cp);
        if (step_cps.size() < MAX_CPS_PER_UNIT)
            step_cps.push_back(cp);
    endfunction

    function automatic void escape_byte(input logic [7:0] b);
        emit(CP_REPLACEMENT);
        emit(hex_char(b[7:4]));
        emit(hex_char(b[3:0]));
    endfunction

    function automatic void escape_unit(input logic [15:0] u);
        emit(CP_REPLACEMENT);
        emit(CP_LETTER_U);
        emit(hex_char(u[15:12]));
        emit(hex_char(u[11:8]));
        emit(hex_char(u[7:4]));
        emit(hex_char(u[3:0]));
    endfunction

    function automatic void drop_sequence();
        held_n  = 0;
        seq_len = 0;
    endfunction

    function automatic void utf8_lead(input logic [7:0] b, input logic eos);
        int unsigned len;
        len = 0;
        if (b < 8'h80)
        begin
            emit({13'b0, b});
            return;
        end
        if ((b & LEAD2_MASK) == LEAD2_PAT)
            len = 2;
        else if ((b & LEAD3_MASK) == LEAD3_PAT)
            len = 3;
        else if ((b & LEAD4_MASK) == LEAD4_PAT)
            len = 4;
        if (len == 0 || eos)
        begin
            escape_byte(b);
            return;
        end
        held[0] = {8'h00, b};
        held_n  = 1;
        seq_len = len;
    endfunction

    // Every held byte is escaped; continuations behind the lead count as invalid leads
    function automatic void escape_held_bytes();
        for (int k = 0; k < held_n && k < 3; k++)
            escape_byte(held[k][7:0]);
        drop_sequence();
    endfunction

    function automatic void utf8_step(input logic [7:0] b, input logic eos);
        logic [31:0] cp;
        logic [7:0]  mask;
        if (seq_len == 0 || held_n == 0)
        begin
            drop_sequence();
            utf8_lead(b, eos);
        end
        else if (b[7:6] == CONT_PAT)
        begin
            if (held_n + 1 >= seq_len)
            begin
                mask = (seq_len == 2) ? 8'h1F : (seq_len == 3) ? 8'h0F : 8'h07;
                cp = {24'b0, held[0][7:0] & mask};
                for (int k = 1; k < held_n && k < 3; k++)
                    cp = (cp << 6) | {26'b0, held[k][5:0]};
                cp = (cp << 6) | {26'b0, b[5:0]};
                emit(cp[20:0]);
                drop_sequence();
            end
            else if (eos)
            begin
                // string cut off inside a sequence
                escape_held_bytes();
                escape_byte(b);
            end
            else if (held_n < 3)
            begin
                held[held_n] = {8'h00, b};
                held_n++;
            end
        end
        else
        begin
            // bad continuation: escape what is held, then restart on this byte
            escape_held_bytes();
            utf8_lead(b, eos);
        end
    endfunction

    function automatic void utf16_lead(input logic [15:0] u, input logic eos);
        if (u < SURR_HI_FIRST || u >= SURR_END)
            emit({5'b0, u});
        else if (u <= SURR_HI_LAST && !eos)
        begin
            held[0] = u;
            held_n  = 1;
            seq_len = 2;
        end
        else
            escape_unit(u);
    endfunction

    function automatic void utf16_step(input logic [15:0] u, input logic eos);
        logic [15:0] hi;
        logic [31:0] w;
        if (seq_len == 0 || held_n == 0)
        begin
            drop_sequence();
            utf16_lead(u, eos);
        end
        else
        begin
            hi = held[0];
            drop_sequence();
            if (u >= SURR_LO_FIRST && u <= SURR_LO_LAST)
            begin
                w = ({16'b0, hi} << 10) + {16'b0, u} - SURR_OFFSET;
                emit(w[20:0]);
            end
            else
            begin
                escape_unit(hi);
                utf16_lead(u, eos);
            end
        end
    endfunction

    // Work out the code points one accepted unit gives and queue them
    function automatic void decode_unit(input logic [15:0] u, input logic eos);
        cp_result_t r;
        step_cps.delete();
        if (src_enc == ENC_UTF16)
            utf16_step(u, eos);
        else
            utf8_step(u[7:0], eos);
        if (eos)
            drop_sequence();
        for (int i = 0; i < step_cps.size(); i++)
        begin
            r.cp = step_cps[i];
            r.rl = (i == step_cps.size() - 1);
            r.sl = r.rl && eos;
            pending_cps.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    function automatic void add_unit(input logic [15:0] u, input logic eos);
        unit_item_t it;
        it.u   = u;
        it.eos = eos;
        unit_fifo.push_back(it);
    endfunction

    // Byte with random upper bits, which UTF-8 mode ignores
    function automatic void add_byte(input logic [7:0] b, input logic eos);
        logic [7:0] hi;
        hi = 8'($urandom_range(255));
        add_unit({hi, b}, eos);
    endfunction

    function automatic logic [7:0] rand_cont();
        logic [5:0] r;
        r = 6'($urandom_range(63));
        return {2'b10, r};
    endfunction

    function automatic logic [7:0] rand_lead(input int unsigned len);
        logic [7:0] r;
        r = 8'($urandom_range(255));
        case (len)
            1:       return {1'b0, r[6:0]};
            2:       return {3'b110, r[4:0]};
            3:       return {4'b1110, r[3:0]};
            default: return {5'b11110, r[2:0]};
        endcase
    endfunction

    function automatic void add_utf8_random(input int unsigned n);
        int unsigned start;
        int unsigned sel;
        int unsigned len;
        int unsigned conts;
        logic [7:0]  b;
        start = unit_fifo.size();
        while (unit_fifo.size() - start < n)
        begin
            sel = $urandom_range(99);
            if (sel < 60)
            begin
                // well-formed character, overlong forms included
                len = $urandom_range(1, 4);
                b = rand_lead(len);
                add_byte(b, len == 1 && $urandom_range(5) == 0);
                for (int k = 1; k < len; k++)
                    add_byte(rand_cont(), k == len - 1 && $urandom_range(5) == 0);
            end
            else if (sel < 75)
            begin
                // truncated sequence, often ended by the end of the string
                len = $urandom_range(2, 4);
                conts = $urandom_range(0, len - 2);
                add_byte(rand_lead(len), conts == 0 && $urandom_range(1) == 0);
                for (int k = 1; k <= conts; k++)
                    add_byte(rand_cont(), k == conts && $urandom_range(1) == 0);
            end
            else if (sel < 88)
            begin
                b = 8'($urandom_range(255));
                add_byte(b, $urandom_range(7) == 0);
            end
            else if (sel < 94)
                add_byte(rand_cont(), $urandom_range(7) == 0);
            else
            begin
                b = 8'($urandom_range(8'hF8, 8'hFF));
                add_byte(b, $urandom_range(7) == 0);
            end
        end
    endfunction

    function automatic void add_utf16_random(input int unsigned n);
        int unsigned start;
        int unsigned sel;
        logic [15:0] u;
        logic [9:0]  r;
        start = unit_fifo.size();
        while (unit_fifo.size() - start < n)
        begin
            sel = $urandom_range(99);
            r = 10'($urandom_range(1023));
            if (sel < 55)
            begin
                // BMP character outside the surrogate range
                if ($urandom_range(1) == 0)
                    u = 16'($urandom_range(16'h0000, 16'hD7FF));
                else
                    u = 16'($urandom_range(16'hE000, 16'hFFFF));
                add_unit(u, $urandom_range(7) == 0);
            end
            else if (sel < 80)
            begin
                add_unit(SURR_HI_FIRST | {6'b0, r}, 1'b0);
                r = 10'($urandom_range(1023));
                add_unit(SURR_LO_FIRST | {6'b0, r}, $urandom_range(5) == 0);
            end
            else if (sel < 87)
                add_unit(SURR_LO_FIRST | {6'b0, r}, $urandom_range(7) == 0);
            else if (sel < 93)
                add_unit(SURR_HI_FIRST | {6'b0, r}, $urandom_range(3) == 0);
            else
            begin
                u = 16'($urandom_range(16'hFFFF));
                add_unit(u, $urandom_range(7) == 0);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Input driver: one unit transfer per accepted push
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin : drive_units
        unit_item_t nxt;
        if (!rst_n)
        begin
            push          <= 1'b0;
            unit          <= '0;
            end_of_string <= 1'b0;
        end
        else if (!push || !full)
        begin
            if (push)
                decode_unit(unit, end_of_string);
            if (unit_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = unit_fifo.pop_front();
                push          <= 1'b1;
                unit          <= nxt.u;
                end_of_string <= nxt.eos;
            end
            else
                push <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each popped code point with the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin : check_results
        cp_result_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (pending_cps.size() == 0)
                begin
                    $error("unexpected result: code_point %h", code_point);
                    mismatches++;
                end
                else
                begin
                    want = pending_cps.pop_front();
                    if (code_point !== want.cp)
                    begin
                        $error("code_point: expected %h, actual %h", want.cp, code_point);
                        mismatches++;
                    end
                    if (run_last !== want.rl)
                    begin
                        $error("run_last: expected %b, actual %b", want.rl, run_last);
                        mismatches++;
                    end
                    if (string_last !== want.sl)
                    begin
                        $error("string_last: expected %b, actual %b", want.sl, string_last);
                        mismatches++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Cycles without any transfer on either side
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
    end

    // ------------------------------------------------------------------
    // Register access and sequencing
    // ------------------------------------------------------------------

    task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // write lands at this edge
        if (addr == ADDR_SRC_ENC)
        begin
            src_enc = data[0];
            drop_sequence();
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_check_read(input logic [PADDR_W-1:0] addr);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {{(PDATA_W-1){1'b0}}, src_enc})
        begin
            $error("source_encoding: expected %h, actual %h", src_enc, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Block idle: all units sent, all results in, and time for a unit that gave none
    task automatic wait_idle();
        while (unit_fifo.size() != 0 || push || pending_cps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic enc, input int s_pct, input int r_pct,
                             input bit directed, input int unsigned n_random);
        logic [PDATA_W-1:0] junk;
        wait_idle();
        junk = $urandom;
        cfg_write(ADDR_SRC_ENC, {junk[PDATA_W-1:1], enc});
        cfg_write(ADDR_UNMAPPED, {junk[PDATA_W-1:1], ~enc});
        cfg_check_read(ADDR_SRC_ENC);
        send_idle_pct <= s_pct;
        recv_idle_pct <= r_pct;
        if (directed && enc == ENC_UTF8)
        begin
            add_unit(16'h0000, 1'b0);                     // zero byte
            add_unit(16'hFF7F, 1'b0);                     // upper bits ignored
            add_unit(16'h00C0, 1'b0);                     // overlong NUL accepted
            add_unit(16'h0080, 1'b0);
            add_unit(16'h00F7, 1'b0);                     // largest 21-bit code point
            add_unit(16'h00BF, 1'b0);
            add_unit(16'h00BF, 1'b0);
            add_unit(16'h00BF, 1'b0);
            add_unit(16'h00F0, 1'b0);                     // bad continuation after two
            add_unit(16'h0090, 1'b0);
            add_unit(16'h0041, 1'b0);
            add_unit(16'h0080, 1'b0);                     // stray continuation
            add_unit(16'h00FF, 1'b0);                     // invalid lead
            add_unit(16'h00E2, 1'b0);                     // cut off by end of string
            add_unit(16'h0082, 1'b1);
            add_unit(16'h00C3, 1'b1);                     // lead on end of string
        end
        else if (directed)
        begin
            add_unit(16'h0000, 1'b0);
            add_unit(16'hFFFF, 1'b0);
            add_unit(SURR_HI_FIRST, 1'b0);                // lowest pair
            add_unit(SURR_LO_FIRST, 1'b0);
            add_unit(SURR_HI_LAST, 1'b0);                 // highest pair
            add_unit(SURR_LO_LAST, 1'b1);
            add_unit(SURR_LO_FIRST, 1'b0);                // lone low surrogate
            add_unit(SURR_HI_FIRST, 1'b0);                // high not followed by low
            add_unit(16'h0041, 1'b0);
            add_unit(SURR_HI_LAST, 1'b1);                 // high on end of string
        end
        if (enc == ENC_UTF16)
            add_utf16_random(n_random);
        else
            add_utf8_random(n_random);
    endtask

    initial
    begin
        src_enc = ENC_UTF8;
        drop_sequence();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        fork
            begin
                run_phase(ENC_UTF8,  34, 52, 1'b1, 100);
                run_phase(ENC_UTF16, 34, 52, 1'b1, 100);
                run_phase(ENC_UTF8,  52, 34, 1'b0, 70);
                run_phase(ENC_UTF16, 52, 34, 1'b0, 70);
                run_phase(ENC_UTF8,  0,  0,  1'b0, 45);
                run_phase(ENC_UTF16, 0,  0,  1'b0, 45);
                wait_idle();
            end
            begin
                while (idle_run < WATCHDOG_LIMIT)
                    @(posedge clk);
                timed_out = 1;
            end
        join_any
        disable fork;
        if (pending_cps.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_cps.size());
            mismatches++;
        end
        if (!timed_out && mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
